// File: src/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cswfm_pkg.sv
// Package of the candidate picker: sizes, register and command codes, shared types.
// No dependencies; the failure memory, the top level and the testbench import it.
package cswfm_pkg;

  localparam int MAX_CANDIDATES = 8;
  // The 3-bit index and group ids reach eight slots at most.
  localparam int SLOT_LIMIT = (MAX_CANDIDATES < 8) ? MAX_CANDIDATES : 8;
  localparam int SLOT_W     = (SLOT_LIMIT > 1) ? $clog2(SLOT_LIMIT) : 1;
  localparam int CNT_W      = $clog2(SLOT_LIMIT + 1);
  localparam int COUNT_W    = 8;
  localparam int TIME_W     = 32;
  localparam int ENTRY_W    = COUNT_W + TIME_W;

  localparam logic [COUNT_W-1:0] COUNT_SAT = 8'hFF;

  typedef enum logic [1:0] {
    CFG_CANDIDATE_COUNT = 2'd0,
    CFG_SSID_GROUP      = 2'd1,
    CFG_FAIL_THRESHOLD  = 2'd2,
    CFG_FAIL_WINDOW     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMD_FAIL       = 3'd0,
    CMD_DEPRIO     = 3'd1,
    CMD_SUCCESS    = 3'd2,
    CMD_PICK_SCAN  = 3'd3,
    CMD_SEQUENTIAL = 3'd4,
    CMD_BETTER     = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_WALK,
    ST_DONE
  } state_t;

  // Access request from the controller to the failure memory.
  typedef struct packed {
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    logic [COUNT_W-1:0]  wr_count;
    logic [TIME_W-1:0]   wr_time;
  } mem_req_t;

endpackage

// File: src/cswfm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module cswfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/cswfm_fail_mem.sv
// Failure memory: fail count and last-fail time per slot, with valid bits for reset.
// Depends on cswfm_pkg and cswfm_ram; reports the live count of the entry read last cycle.
module cswfm_fail_mem
  import cswfm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  mem_req_t           req,
  input  logic [TIME_W-1:0]  now_ms,
  input  logic [TIME_W-1:0]  window_ms,
  output logic [COUNT_W-1:0] live
);

  logic [SLOT_LIMIT-1:0] valid_r;
  logic                  rd_vld_r;
  logic [ENTRY_W-1:0]    rdata;
  logic [COUNT_W-1:0]    cnt;
  logic [TIME_W-1:0]     age;

  cswfm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_LIMIT)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .waddr (req.wr_addr),
    .wdata ({req.wr_count, req.wr_time}),
    .re    (req.rd_en),
    .raddr (req.rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr];
      end
    end
  end

  // An entry never written reads as zero count and zero time.
  assign cnt  = rd_vld_r ? rdata[ENTRY_W-1:TIME_W] : '0;
  assign age  = now_ms - (rd_vld_r ? rdata[TIME_W-1:0] : '0);
  assign live = ((cnt != '0) && (age < window_ms)) ? cnt : '0;

endmodule

// File: src/candidate_select_with_fail_memory.sv
// Candidate picker with a per-slot failure memory.
// Input channel (in_valid / in_stall): one command item per transfer, carrying the command,
// a slot index, the current millisecond tick and the scan visibility mask.
// Result channel (out_valid / out_stall): exactly one result per input item, in order.
// Configuration port (cfg_we / cfg_index / cfg_wdata): the user must write it only while the
// block is idle, which the block itself does not enforce.
// Each item first sweeps the failure memory, one entry read per cycle over all slots,
// to build a deprioritised mask and the live count of the indexed slot. The update
// state then writes back the indexed entry and resolves first-match picks.
// Rotation picks step their cursor once per cycle, up to count + 1 steps.
// From the input transfer the item passes through the scan and update states and, for
// walks, the walk state, before the done state loads the result into the output register.
// in_stall is high from the cycle after a transfer until the result is loaded, so the block
// takes no new item until it is through with the last one; a new item is taken while an
// earlier result still waits on out_stall.
// If the receiver stalls, the result holds in the output register and the finished item
// waits in its last state until the register frees up.
// Reset clears the cursors, the output valid and the memory valid bits, so every slot reads
// as zero count and zero time; configuration returns to its reset values.
// Since only one item is in flight, reads and the single write-back never overlap.
module candidate_select_with_fail_memory
  import cswfm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_command,
  input  logic [2:0]          in_index,
  input  logic [31:0]         in_now_ms,
  input  logic [7:0]          in_visible_mask,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_found,
  output logic [2:0]          out_selected,
  output logic [7:0]          out_live_fail_count,
  output logic                out_deprioritised,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  // Configuration registers.
  logic [3:0]  num_cands_r;
  logic [23:0] ssid_group_r;
  logic [7:0]  threshold_r;
  logic [31:0] window_r;

  // Control state.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  sc_r, sc_nxt;
  logic              pend_r, pend_nxt;
  logic [SLOT_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0]  walk_r, walk_nxt;
  logic              extra_r, extra_nxt;
  logic [SLOT_W-1:0] rot_cur_r, rot_cur_nxt;
  logic              rot_st_r, rot_st_nxt;
  logic [SLOT_W-1:0] fb_cur_r, fb_cur_nxt;
  logic              fb_st_r, fb_st_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Item payload and working registers.
  logic [2:0]            cmd_r, cmd_nxt;
  logic [2:0]            idx_r, idx_nxt;
  logic [31:0]           now_r, now_nxt;
  logic [SLOT_LIMIT-1:0] vis_r, vis_nxt;
  logic [SLOT_LIMIT-1:0] dep_r, dep_nxt;
  logic [COUNT_W-1:0]    live_r, live_nxt;
  logic                  found_r, found_nxt;
  logic [SLOT_W-1:0]     sel_r, sel_nxt;

  // Output payload registers.
  logic                  out_found_r, out_found_nxt;
  logic [2:0]            out_sel_r, out_sel_nxt;
  logic [COUNT_W-1:0]    out_live_r, out_live_nxt;
  logic                  out_dep_r, out_dep_nxt;

  mem_req_t           mem_req;
  logic [COUNT_W-1:0] mem_live;

  logic [CNT_W-1:0]  n_eff;
  logic              slot_ok;
  logic              scan_hit;
  logic [SLOT_W-1:0] scan_sel;
  logic              better_hit;
  logic [SLOT_W-1:0] better_sel;
  logic [2:0]        cur_group;

  cswfm_fail_mem u_fail_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mem_req),
    .now_ms    (now_r),
    .window_ms (window_r),
    .live      (mem_live)
  );

  // Cursor step modulo the count; the cursor may sit past a count that was lowered.
  function automatic logic [SLOT_W-1:0] wrap_next(input logic [SLOT_W-1:0] cur,
                                                  input logic [CNT_W-1:0]  n);
    logic [CNT_W:0] a;
    a = {1'b0, CNT_W'(cur)} + 1'b1;
    for (int k = 0; k < SLOT_LIMIT; k++) begin
      if (a >= {1'b0, n}) begin
        a = a - {1'b0, n};
      end
    end
    return a[SLOT_W-1:0];
  endfunction

  assign n_eff   = (num_cands_r > 4'(SLOT_LIMIT)) ? CNT_W'(SLOT_LIMIT) : CNT_W'(num_cands_r);
  assign slot_ok = ({1'b0, idx_r} < 4'(SLOT_LIMIT));
  assign cur_group = ssid_group_r[3 * int'(idx_r) +: 3];

  // First-match searches over the deprioritised mask; the lowest index wins.
  always_comb begin
    scan_hit   = 1'b0;
    scan_sel   = '0;
    better_hit = 1'b0;
    better_sel = '0;
    for (int i = SLOT_LIMIT - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < n_eff) && vis_r[i] && !dep_r[i]) begin
        scan_hit = 1'b1;
        scan_sel = SLOT_W'(i);
      end
      if ((3'(i) < idx_r) && vis_r[i] && !dep_r[i] &&
          (ssid_group_r[3 * i +: 3] != cur_group)) begin
        better_hit = 1'b1;
        better_sel = SLOT_W'(i);
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cands_r  <= 4'd0;
      ssid_group_r <= 24'd0;
      threshold_r  <= 8'd3;
      window_r     <= 32'd60000;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CANDIDATE_COUNT: num_cands_r  <= cfg_wdata[3:0];
        CFG_SSID_GROUP:      ssid_group_r <= cfg_wdata[23:0];
        CFG_FAIL_THRESHOLD:  threshold_r  <= cfg_wdata[7:0];
        CFG_FAIL_WINDOW:     window_r     <= cfg_wdata;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sc_r        <= '0;
      pend_r      <= 1'b0;
      walk_r      <= '0;
      extra_r     <= 1'b0;
      rot_cur_r   <= '0;
      rot_st_r    <= 1'b0;
      fb_cur_r    <= '0;
      fb_st_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sc_r        <= sc_nxt;
      pend_r      <= pend_nxt;
      walk_r      <= walk_nxt;
      extra_r     <= extra_nxt;
      rot_cur_r   <= rot_cur_nxt;
      rot_st_r    <= rot_st_nxt;
      fb_cur_r    <= fb_cur_nxt;
      fb_st_r     <= fb_st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    now_r      <= now_nxt;
    vis_r      <= vis_nxt;
    dep_r      <= dep_nxt;
    live_r     <= live_nxt;
    found_r    <= found_nxt;
    sel_r      <= sel_nxt;
    out_found_r <= out_found_nxt;
    out_sel_r   <= out_sel_nxt;
    out_live_r  <= out_live_nxt;
    out_dep_r   <= out_dep_nxt;
  end

  always_comb begin
    logic [SLOT_W-1:0] cur;
    logic              started;
    logic [SLOT_W-1:0] c;
    logic              hit;

    state_nxt     = state_r;
    sc_nxt        = sc_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    walk_nxt      = walk_r;
    extra_nxt     = extra_r;
    rot_cur_nxt   = rot_cur_r;
    rot_st_nxt    = rot_st_r;
    fb_cur_nxt    = fb_cur_r;
    fb_st_nxt     = fb_st_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    now_nxt       = now_r;
    vis_nxt       = vis_r;
    dep_nxt       = dep_r;
    live_nxt      = live_r;
    found_nxt     = found_r;
    sel_nxt       = sel_r;
    out_found_nxt = out_found_r;
    out_sel_nxt   = out_sel_r;
    out_live_nxt  = out_live_r;
    out_dep_nxt   = out_dep_r;
    mem_req       = '0;

    cur     = (cmd_r == CMD_PICK_SCAN) ? fb_cur_r : rot_cur_r;
    started = (cmd_r == CMD_PICK_SCAN) ? fb_st_r : rot_st_r;
    c       = started ? wrap_next(cur, n_eff) : '0;
    hit     = (cmd_r == CMD_PICK_SCAN) ? vis_r[c] : (extra_r || !dep_r[c]);

    // The receiver took the waiting result.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // A returning read fills one bit of the mask and, for the indexed slot, its live count.
    if (pend_r) begin
      dep_nxt[pend_idx_r] = (mem_live >= threshold_r);
      if (3'(pend_idx_r) == idx_r) begin
        live_nxt = mem_live;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          idx_nxt   = in_index;
          now_nxt   = in_now_ms;
          vis_nxt   = in_visible_mask[SLOT_LIMIT-1:0];
          live_nxt  = '0;
          sc_nxt    = '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (sc_r < CNT_W'(SLOT_LIMIT)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = sc_r[SLOT_W-1:0];
          pend_nxt        = 1'b1;
          pend_idx_nxt    = sc_r[SLOT_W-1:0];
          sc_nxt          = sc_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        found_nxt = 1'b0;
        sel_nxt   = '0;
        walk_nxt  = '0;
        extra_nxt = 1'b0;
        state_nxt = ST_DONE;
        mem_req.wr_addr = idx_r[SLOT_W-1:0];
        mem_req.wr_time = now_r;
        unique case (cmd_r)
          CMD_FAIL: begin
            mem_req.wr_en    = slot_ok;
            mem_req.wr_count = (live_r < COUNT_SAT) ? live_r + 1'b1 : live_r;
          end
          CMD_DEPRIO: begin
            mem_req.wr_en    = slot_ok;
            mem_req.wr_count = ((live_r == '0) || (live_r < threshold_r)) ? threshold_r : live_r;
          end
          CMD_SUCCESS: begin
            mem_req.wr_en    = slot_ok;
            mem_req.wr_count = '0;
            mem_req.wr_time  = '0;
          end
          CMD_PICK_SCAN: begin
            if (scan_hit) begin
              found_nxt = 1'b1;
              sel_nxt   = scan_sel;
            end else if (n_eff != '0) begin
              state_nxt = ST_WALK;
            end
          end
          CMD_SEQUENTIAL: begin
            if (n_eff != '0) begin
              state_nxt = ST_WALK;
            end
          end
          CMD_BETTER: begin
            if ((idx_r != 3'd0) && ({1'b0, idx_r} < 4'(n_eff)) && better_hit) begin
              found_nxt = 1'b1;
              sel_nxt   = better_sel;
            end
          end
          default: begin
          end
        endcase
      end

      ST_WALK: begin
        // One cursor step per cycle; the sequential walk adds one forced step at the end.
        if (cmd_r == CMD_PICK_SCAN) begin
          fb_cur_nxt = c;
          fb_st_nxt  = 1'b1;
        end else begin
          rot_cur_nxt = c;
          rot_st_nxt  = 1'b1;
        end
        walk_nxt = walk_r + 1'b1;
        if (hit) begin
          found_nxt = 1'b1;
          sel_nxt   = c;
          state_nxt = ST_DONE;
        end else if (CNT_W'(walk_r + 1'b1) == n_eff) begin
          if ((cmd_r == CMD_SEQUENTIAL) && !extra_r) begin
            extra_nxt = 1'b1;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_sel_nxt   = 3'(sel_r);
          out_live_nxt  = live_r;
          out_dep_nxt   = (live_r >= threshold_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_selected        = out_sel_r;
  assign out_live_fail_count = out_live_r;
  assign out_deprioritised   = out_dep_r;

endmodule

// File: src/cswfm_checker.sv
// Port-level checker for the candidate picker, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cswfm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic [2:0]  out_selected,
  input logic [7:0]  out_live_fail_count,
  input logic        out_deprioritised
);

  `CSW_ASSERT_IMP(a_sel_zero, out_valid && !out_found, out_selected == 3'd0, "selected not zero without a find")
  `CSW_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_found) && $stable(out_selected) && $stable(out_live_fail_count) && $stable(out_deprioritised), "stalled result changed")
  `CSW_ASSERT_NXT(a_busy, in_valid && !in_stall, in_stall && !$rose(out_valid), "block not busy after an input transfer")
  `CSW_ASSERT_IMP(a_rst, $past(!rst_n), !out_valid, "result valid right after reset")

endmodule

bind candidate_select_with_fail_memory cswfm_checker u_cswfm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_found           (out_found),
  .out_selected        (out_selected),
  .out_live_fail_count (out_live_fail_count),
  .out_deprioritised   (out_deprioritised)
);

// File: sim/tb_candidate_select_with_fail_memory.sv
// Self-checking testbench for the candidate picker with per-slot failure memory.
// It drives directed and random command items under several register settings.
// A scoreboard class predicts each result. Depends on cswfm_pkg and candidate_select_with_fail_memory.
module tb_candidate_select_with_fail_memory;
  timeunit 1ns;
  timeprecision 1ps;
  import cswfm_pkg::*;

  localparam int RESET_CYCLES  = 6;
  localparam int LONG_HOLD     = 300;
  // Wait after the last result, so that the block settles into idle.
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 400000;

  // Commands 6 and 7 have no meaning in the block; they must leave every bit of state alone.
  localparam logic [2:0] CMD_NONE_A = 3'd6;
  localparam logic [2:0] CMD_NONE_B = 3'd7;

  // One result item, in the order of the output ports.
  typedef struct packed {
    logic       found;
    logic [2:0] selected;
    logic [7:0] live_count;
    logic       deprioritised;
  } pick_result_t;

  // The scoreboard keeps its own copy of the registers and the failure memory. It also keeps
  // both cursors. Every input transfer pushes the predicted result. Every result transfer
  // pops the oldest prediction and compares it field by field.
  class pick_scoreboard;
    logic [3:0]   num_cands;
    logic [23:0]  name_groups;
    logic [7:0]   threshold;
    logic [31:0]  window_ms;
    logic [7:0]   fail_cnt [8];
    logic [31:0]  fail_at [8];
    logic [2:0]   rot_cur;
    bit           rot_started;
    logic [2:0]   fb_cur;
    bit           fb_started;
    pick_result_t awaited [$];
    int           errors;

    function new();
      num_cands   = '0;
      name_groups = '0;
      threshold   = 8'd3;
      window_ms   = 32'd60000;
      foreach (fail_cnt[i]) begin
        fail_cnt[i] = '0;
        fail_at[i]  = '0;
      end
      rot_cur     = '0;
      rot_started = 1'b0;
      fb_cur      = '0;
      fb_started  = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_reg_t which, logic [31:0] value);
      case (which)
        CFG_CANDIDATE_COUNT: num_cands   = value[3:0];
        CFG_SSID_GROUP:      name_groups = value[23:0];
        CFG_FAIL_THRESHOLD:  threshold   = value[7:0];
        CFG_FAIL_WINDOW:     window_ms   = value;
        default: ;
      endcase
    endfunction

    // A streak counts only while its age, taken modulo 2^32, is below the window.
    function logic [7:0] live_of(int slot, logic [31:0] now);
      logic [31:0] age;
      age = now - fail_at[slot];
      if (fail_cnt[slot] == '0 || age >= window_ms) return '0;
      return fail_cnt[slot];
    endfunction

    function bit held_back(int slot, logic [31:0] now);
      return live_of(slot, now) >= threshold;
    endfunction

    // The first step after reset lands on slot 0. Each later step advances modulo the count.
    function logic [2:0] advance(inout logic [2:0] cur, inout bit started, input int n);
      cur = started ? 3'((int'(cur) + 1) % n) : 3'd0;
      started = 1'b1;
      return cur;
    endfunction

    function void note_input(logic [2:0] cmd, logic [2:0] idx, logic [31:0] now,
                             logic [7:0] vis);
      pick_result_t r;
      logic [2:0]   c;
      int           n;
      n = (num_cands > 4'd8) ? 8 : int'(num_cands);
      r = '0;
      r.live_count    = live_of(idx, now);
      r.deprioritised = r.live_count >= threshold;
      case (cmd)
        CMD_FAIL: begin
          fail_cnt[idx] = (r.live_count < COUNT_SAT) ? r.live_count + 8'd1 : r.live_count;
          fail_at[idx]  = now;
        end
        CMD_DEPRIO: begin
          if (r.live_count == '0 || r.live_count < threshold) fail_cnt[idx] = threshold;
          fail_at[idx] = now;
        end
        CMD_SUCCESS: begin
          fail_cnt[idx] = '0;
          fail_at[idx]  = '0;
        end
        CMD_PICK_SCAN: begin
          for (int i = 0; i < n && !r.found; i++) begin
            if (vis[i] && !held_back(i, now)) begin
              r.found    = 1'b1;
              r.selected = 3'(i);
            end
          end
          for (int i = 0; i < n && !r.found; i++) begin
            c = advance(fb_cur, fb_started, n);
            if (vis[c]) begin
              r.found    = 1'b1;
              r.selected = c;
            end
          end
        end
        CMD_SEQUENTIAL: begin
          if (n != 0) begin
            for (int i = 0; i < n && !r.found; i++) begin
              c = advance(rot_cur, rot_started, n);
              if (!held_back(c, now)) begin
                r.found    = 1'b1;
                r.selected = c;
              end
            end
            // When every slot is held back, the rotation takes one extra step.
            if (!r.found) begin
              r.selected = advance(rot_cur, rot_started, n);
              r.found    = 1'b1;
            end
          end
        end
        CMD_BETTER: begin
          if (idx != '0 && int'(idx) < n) begin
            for (int i = 0; i < int'(idx) && !r.found; i++) begin
              if (vis[i] && !held_back(i, now) &&
                  name_groups[3*i +: 3] != name_groups[3*int'(idx) +: 3]) begin
                r.found    = 1'b1;
                r.selected = 3'(i);
              end
            end
          end
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void flag(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_result(pick_result_t got);
      pick_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        return;
      end
      want = awaited.pop_front();
      if (got.found !== want.found) flag("found", want.found, got.found);
      if (got.selected !== want.selected) flag("selected", want.selected, got.selected);
      if (got.live_count !== want.live_count)
        flag("live_fail_count", want.live_count, got.live_count);
      if (got.deprioritised !== want.deprioritised)
        flag("deprioritised", want.deprioritised, got.deprioritised);
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_command;
  logic [2:0]  in_index;
  logic [31:0] in_now_ms;
  logic [7:0]  in_visible_mask;
  logic        out_valid;
  logic        out_stall;
  logic        out_found;
  logic [2:0]  out_selected;
  logic [7:0]  out_live_fail_count;
  logic        out_deprioritised;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  pick_scoreboard sb = new();
  // While quiet is set, neither side idles.
  bit          quiet = 1'b0;
  // The stimulus raises this flag to ask the receiver for one long hold-off.
  bit          long_hold_req = 1'b0;
  // Running millisecond tick. Random items move it forward in steps scaled to the window.
  logic [31:0] clock_ms = '0;
  int unsigned cycles = 0;

  candidate_select_with_fail_memory i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_index            (in_index),
    .in_now_ms           (in_now_ms),
    .in_visible_mask     (in_visible_mask),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_found           (out_found),
    .out_selected        (out_selected),
    .out_live_fail_count (out_live_fail_count),
    .out_deprioritised   (out_deprioritised),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both channels are sampled at the clock edge, before the edge's own updates land. The
  // result check runs before the input is noted, because a result never belongs to an item
  // that transfers at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result('{out_found, out_selected, out_live_fail_count, out_deprioritised});
      if (in_valid && !in_stall)
        sb.note_input(in_command, in_index, in_now_ms, in_visible_mask);
    end
  end

  // Receiver side. It stalls in short random bursts. On request it holds off until the loop
  // here has counted to LONG_HOLD, so that one result sits in the output register and the next item
  // finishes behind it. The input channel then stalls while the sender keeps offering.
  initial begin : receiver
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        for (int held = 0; held < LONG_HOLD; held++) @(posedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one item and returns at the edge where it transfers. Valid stays high afterward,
  // so the next call can present its item at the same time step without a dip. A random gap
  // lowers valid at the start of a call instead.
  task automatic send_item(logic [2:0] cmd, logic [2:0] idx, logic [31:0] now,
                           logic [7:0] vis);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_index        <= idx;
    in_now_ms       <= now;
    in_visible_mask <= vis;
    do @(posedge clk); while (in_stall);
  endtask

  // Random item. Events outweigh picks so that streaks build up and picks meet held-back
  // slots. Now and then the tick jumps a full window, which puts the age right at the
  // window edge, or it jumps anywhere, which ages every streak out or wraps it.
  task automatic send_random();
    logic [2:0] cmd;
    logic [7:0] vis;
    int         roll;
    int         step_max;
    roll = $urandom_range(0, 99);
    if (roll < 35)      cmd = CMD_FAIL;
    else if (roll < 45) cmd = CMD_DEPRIO;
    else if (roll < 53) cmd = CMD_SUCCESS;
    else if (roll < 68) cmd = CMD_PICK_SCAN;
    else if (roll < 83) cmd = CMD_SEQUENTIAL;
    else if (roll < 96) cmd = CMD_BETTER;
    else if (roll < 98) cmd = CMD_NONE_A;
    else                cmd = CMD_NONE_B;
    step_max = (sb.window_ms > 32'd4000) ? 1000 : int'(sb.window_ms / 4) + 1;
    roll = $urandom_range(0, 19);
    if (roll == 0)      clock_ms = $urandom();
    else if (roll == 1) clock_ms = clock_ms + sb.window_ms;
    else                clock_ms = clock_ms + $urandom_range(0, step_max);
    roll = $urandom_range(0, 9);
    if (roll == 0)      vis = 8'h00;
    else if (roll == 1) vis = 8'hFF;
    else if (roll == 2) vis = 8'(1 << $urandom_range(0, 7));
    else                vis = 8'($urandom());
    send_item(cmd, 3'($urandom_range(0, 7)), clock_ms, vis);
  endtask

  // Lowers valid and waits for the last result. The first edge lets the sampler note the
  // item that transferred just before. The block then has time to settle into idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers back to back, in index order. The block must be idle.
  task automatic program_regs(logic [3:0] count, logic [23:0] groups, logic [7:0] thr,
                              logic [31:0] win);
    logic [31:0] vals [4];
    vals = '{32'(count), 32'(groups), 32'(thr), win};
    for (int r = 0; r < 4; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(r);
      cfg_wdata <= vals[r];
      @(posedge clk);
      sb.set_reg(cfg_reg_t'(r), vals[r]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    in_valid        <= 1'b0;
    in_command      <= CMD_FAIL;
    in_index        <= '0;
    in_now_ms       <= '0;
    in_visible_mask <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_CANDIDATE_COUNT;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: with no candidates in use, every pick finds nothing.
    send_item(CMD_SEQUENTIAL, 3'd0, 32'd0, 8'hFF);
    send_item(CMD_PICK_SCAN, 3'd0, 32'd10, 8'hFF);
    send_item(CMD_FAIL, 3'd7, 32'd20, 8'h00);
    send_item(CMD_BETTER, 3'd1, 32'd30, 8'hFF);
    drain();

    // Eight candidates in name pairs (0,1), (2,3), (4,5) and (6,7). Two failures deprioritise.
    program_regs(4'd8, 24'o33221100, 8'd2, 32'd1000);
    send_item(CMD_FAIL, 3'd0, 32'd100, 8'h00);
    send_item(CMD_FAIL, 3'd0, 32'd200, 8'h00);
    // Slot 0 is the only visible slot and it is held back, so the fallback rotation picks it.
    send_item(CMD_PICK_SCAN, 3'd0, 32'd300, 8'h01);
    // Nothing is visible, so the fallback walks the whole list and finds nothing.
    send_item(CMD_PICK_SCAN, 3'd0, 32'd300, 8'h00);
    send_item(CMD_PICK_SCAN, 3'd0, 32'd300, 8'hFF);
    send_item(CMD_SEQUENTIAL, 3'd0, 32'd300, 8'h00);
    send_item(CMD_SEQUENTIAL, 3'd0, 32'd300, 8'h00);
    send_item(CMD_DEPRIO, 3'd3, 32'd400, 8'h00);
    send_item(CMD_BETTER, 3'd7, 32'd500, 8'hFF);
    send_item(CMD_BETTER, 3'd1, 32'd500, 8'hFF);
    // Slot 2 shares its name with the current connection on slot 3, so it is no better.
    send_item(CMD_BETTER, 3'd3, 32'd500, 8'h06);
    send_item(CMD_BETTER, 3'd0, 32'd500, 8'hFF);
    send_item(CMD_SUCCESS, 3'd0, 32'd600, 8'h00);
    // A streak that spans the wrap of the tick stays live.
    send_item(CMD_FAIL, 3'd5, 32'hFFFF_FFF0, 8'h00);
    send_item(CMD_FAIL, 3'd5, 32'h0000_0010, 8'h00);
    // The streak on slot 3 has aged out, so the count restarts.
    send_item(CMD_FAIL, 3'd3, 32'd2000, 8'h00);
    // A live count at the threshold is left as it is.
    send_item(CMD_DEPRIO, 3'd5, 32'h0000_0020, 8'h00);
    send_item(CMD_NONE_A, 3'd5, 32'h0000_0020, 8'hFF);
    send_item(CMD_NONE_B, 3'd7, 32'hFFFF_FFFF, 8'hFF);
    send_item(CMD_FAIL, 3'd7, 32'hFFFF_FFFF, 8'hFF);
    clock_ms = 32'd3000;
    // Random items under the same settings, with one long hold-off on the result side.
    for (int k = 0; k < 110; k++) begin
      if (k == 40) long_hold_req = 1'b1;
      send_random();
    end
    drain();

    // A single candidate, a threshold of one and the shortest nonzero window.
    program_regs(4'd1, 24'($urandom()), 8'd1, 32'd1);
    for (int k = 0; k < 110; k++) send_random();
    drain();

    // The highest threshold and the longest window. Repeated failures on one slot saturate
    // its count, and the random items that follow see it.
    program_regs(4'd5, 24'($urandom()), 8'd255, 32'hFFFF_FFFF);
    for (int k = 0; k < 270; k++) begin
      clock_ms = clock_ms + $urandom_range(0, 50);
      send_item(CMD_FAIL, 3'd2, clock_ms, 8'($urandom()));
    end
    for (int k = 0; k < 60; k++) send_random();
    drain();

    // The count register is past the slot limit and gets clamped. A threshold of zero holds
    // back every slot, and a window of zero keeps every streak dead.
    program_regs(4'd15, 24'hFF_FFFF, 8'd0, 32'd0);
    for (int k = 0; k < 110; k++) send_random();
    drain();

    // Every candidate has the same name, so a better pick never exists.
    program_regs(4'd3, 24'h00_0000, 8'd3, 32'd60000);
    for (int k = 0; k < 110; k++) send_random();
    drain();

    // The last stretch runs with no idling on either side.
    quiet = 1'b1;
    program_regs(4'd8, 24'($urandom()), 8'd4, 32'd500);
    for (int k = 0; k < 110; k++) send_random();
    drain();

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/cswfm_pkg.sv
src/cswfm_ram.sv
src/cswfm_fail_mem.sv
src/candidate_select_with_fail_memory.sv
src/cswfm_checker.sv
sim/tb_candidate_select_with_fail_memory.sv
